@@ sv/ptpll_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the pilot tone PLL tracker.
// Register indexes, reset values and the quarter-wave sine generator.
// No dependencies.
package ptpll_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;
    localparam int PHASE_W    = 32;
    localparam int FREQ_W     = 40;
    localparam int COEF_W     = 31;
    localparam int POLE_W     = 32;
    localparam int TRIG_W     = 17;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_POLE_REAL   = 3'd0;
    localparam t_cfg_idx CFG_POLE_IMAG   = 3'd1;
    localparam t_cfg_idx CFG_SMOOTHER    = 3'd2;
    localparam t_cfg_idx CFG_INTEGRATOR  = 3'd3;
    localparam t_cfg_idx CFG_PROPORTION  = 3'd4;
    localparam t_cfg_idx CFG_AMP_START   = 3'd5;

    localparam logic [COEF_W-1:0]     SMOOTHER_RST  = 31'd52367462;
    localparam logic [COEF_W-1:0]     INTEGRATOR_RST = 31'd543964;
    localparam logic [COEF_W-1:0]     PROPORTION_RST = 31'd15385646;
    localparam logic [CFG_DATA_W-1:0] AMP_START_RST  = 40'd16777216;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint ONE_Q30     = 64'sd1073741824;

    // Quarter-wave sine magnitude in Q1.15 for step k of 2^qb.
    function automatic logic [TRIG_W-1:0] sine_quarter(input int k, input int qb);
        longint x;
        longint x2;
        longint t;
        longint s;
        x  = (longint'(k) * HALF_PI_Q30) >>> qb;
        x2 = (x * x + (64'sd1 <<< 29)) >>> 30;
        t  = ONE_Q30 - x2 / 72;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 42;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 20;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 6;
        s  = (x * t) >>> 30;
        s  = (s + 64'sd16384) >>> 15;
        if (s > 64'sd32768) begin
            s = 64'sd32768;
        end
        return s[TRIG_W-1:0];
    endfunction

endpackage

@@ sv/pilot_tone_pll_tracker_core.sv @@
`timescale 1ns / 1ps
// Pilot tone tracker: cascaded complex band-pass, amplitude smoother and PLL.
// Depends on ptpll_pkg.
//
// One complex sample in, one 32-bit wrapping phase out. All arithmetic runs on
// one 33x31 multiplier under a microcode sequencer: fourteen products, each in
// a low, a high and an accumulate step, a radix-2 divider for the phase error
// and one final step. The input is not ready while an item is in work; a
// finished phase waits in an output register, and while an earlier phase there
// is not yet taken the sequencer holds its last step and the input stays not
// ready.
// Configuration writes take effect at once and must happen while idle; writing
// the amplitude start register also reloads both amplitude stages.
module pilot_tone_pll_tracker_core #(
    parameter int SAMPLE_BITS     = 16,
    parameter int STATE_BITS      = 40,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ptpll_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ptpll_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                 i_sample_valid,
    output logic                                 o_sample_ready,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample_re,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample_im,
    output logic                                 o_phase_valid,
    input  logic                                 i_phase_ready,
    output logic [ptpll_pkg::PHASE_W-1:0]        o_phase_out
);

    localparam int S     = STATE_BITS;
    localparam int A_W   = 33;
    localparam int B_W   = S + 2;
    localparam int BH_W  = B_W - 30;
    localparam int P_W   = A_W + B_W + 1;
    localparam int SUM_W = S + 4;
    localparam int IN_SH = 25 - SAMPLE_BITS;
    localparam int QB    = SINE_TABLE_BITS - 2;
    localparam int AW    = ((S > 40) ? S : 40) + 1;
    localparam int TW    = ptpll_pkg::TRIG_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LO    = 3'd1;
    localparam logic [2:0] ST_HI    = 3'd2;
    localparam logic [2:0] ST_ACC   = 3'd3;
    localparam logic [2:0] ST_DINIT = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    localparam logic [3:0] OP_S1_RR = 4'd0;
    localparam logic [3:0] OP_S1_II = 4'd1;
    localparam logic [3:0] OP_S1_RI = 4'd2;
    localparam logic [3:0] OP_S1_IR = 4'd3;
    localparam logic [3:0] OP_S2_RR = 4'd4;
    localparam logic [3:0] OP_S2_II = 4'd5;
    localparam logic [3:0] OP_S2_RI = 4'd6;
    localparam logic [3:0] OP_S2_IR = 4'd7;
    localparam logic [3:0] OP_AMP_F = 4'd8;
    localparam logic [3:0] OP_AMP_S = 4'd9;
    localparam logic [3:0] OP_COS   = 4'd10;
    localparam logic [3:0] OP_SIN   = 4'd11;
    localparam logic [3:0] OP_INT   = 4'd12;
    localparam logic [3:0] OP_PROP  = 4'd13;

    localparam logic signed [P_W-1:0] RND30 = {{(P_W-30){1'b0}}, 1'b1, 29'd0};
    localparam logic signed [P_W-1:0] RND20 = {{(P_W-20){1'b0}}, 1'b1, 19'd0};
    localparam logic signed [P_W-1:0] RND15 = {{(P_W-15){1'b0}}, 1'b1, 14'd0};
    localparam logic [QB:0]           QFULL = {1'b1, {QB{1'b0}}};

    function automatic logic signed [S-1:0] sat_state(input logic signed [SUM_W-1:0] v);
        logic all_one;
        logic all_zero;
        all_one  = &v[SUM_W-1:S-1];
        all_zero = ~|v[SUM_W-1:S-1];
        if (all_one || all_zero) begin
            return v[S-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(S-1){1'b0}}};
        end
        return {1'b0, {(S-1){1'b1}}};
    endfunction

    function automatic logic [S-1:0] sat_amp(input logic signed [SUM_W-1:0] v);
        if (v[SUM_W-1]) begin
            return '0;
        end else if (|v[SUM_W-2:S]) begin
            return '1;
        end
        return v[S-1:0];
    endfunction

    function automatic logic [S-1:0] sat_cfg_amp(input logic [ptpll_pkg::CFG_DATA_W-1:0] v);
        logic [AW-1:0] ext;
        ext = {{(AW-40){1'b0}}, v};
        if (|ext[AW-1:S]) begin
            return '1;
        end
        return ext[S-1:0];
    endfunction

    logic [2:0]                   r_state;
    logic [3:0]                   r_op;
    logic [4:0]                   r_cnt;
    logic signed [SAMPLE_BITS-1:0] r_xr;
    logic signed [SAMPLE_BITS-1:0] r_xi;
    logic signed [31:0]           r_pr;
    logic signed [31:0]           r_pi;
    logic [30:0]                  r_sc;
    logic [30:0]                  r_ic;
    logic [30:0]                  r_pc;
    logic signed [S-1:0]          r_s1r;
    logic signed [S-1:0]          r_s1i;
    logic signed [S-1:0]          r_s2r;
    logic signed [S-1:0]          r_s2i;
    logic signed [S-1:0]          r_hold;
    logic [S-1:0]                 r_af;
    logic [S-1:0]                 r_as;
    logic [39:0]                  r_freq;
    logic [31:0]                  r_phase;
    logic signed [SUM_W-1:0]      r_sum;
    logic signed [P_W-1:0]        r_acc;
    logic [S-1:0]                 r_rem;
    logic [31:0]                  r_q;
    logic                         r_neg;
    logic                         r_dsat;
    logic                         r_ov;
    logic [31:0]                  r_out;

    logic [TW-1:0]           w_tab [0:(1 << QB)];
    logic signed [A_W-1:0]   w_a;
    logic signed [B_W-1:0]   w_b;
    logic signed [30:0]      w_mb;
    logic signed [63:0]      w_prod;
    logic signed [P_W-1:0]   w_prod_x;
    logic [1:0]              w_sh;
    logic signed [P_W-1:0]   w_res;
    logic signed [SUM_W-1:0] w_rs;
    logic [S:0]              w_abs_r;
    logic [S:0]              w_abs_i;
    logic [S+1:0]            w_mag;
    logic signed [TW-1:0]    w_cos;
    logic signed [TW-1:0]    w_sin;
    logic [31:0]             w_cph;
    logic [S-1:0]            w_div;
    logic [SUM_W-1:0]        w_nmag;
    logic [S:0]              w_trial;
    logic [31:0]             w_quo;
    logic signed [32:0]      w_err;
    logic signed [SUM_W-1:0] w_xr;
    logic signed [SUM_W-1:0] w_xi;
    logic [39:0]             w_total;

    for (genvar g = 0; g <= (1 << QB); g++) begin : g_tab
        assign w_tab[g] = ptpll_pkg::sine_quarter(g, QB);
    end

    function automatic logic signed [TW-1:0] trig(input logic [31:0] ph,
                                                  input logic [TW-1:0] tab [0:(1 << QB)]);
        logic [SINE_TABLE_BITS-1:0] idx;
        logic [QB:0]                k;
        logic [TW-1:0]              mag;
        idx = ph[31 -: SINE_TABLE_BITS];
        k   = {1'b0, idx[QB-1:0]};
        if (idx[QB]) begin
            k = QFULL - k;
        end
        mag = tab[k];
        return idx[QB+1] ? -$signed(mag) : $signed(mag);
    endfunction

    assign w_cph = r_phase + 32'h4000_0000;
    assign w_cos = trig(w_cph, w_tab);
    assign w_sin = trig(r_phase, w_tab);

    assign w_abs_r = r_s2r[S-1] ? ((S+1)'(0) - {r_s2r[S-1], r_s2r}) : {1'b0, r_s2r};
    assign w_abs_i = r_s2i[S-1] ? ((S+1)'(0) - {r_s2i[S-1], r_s2i}) : {1'b0, r_s2i};
    assign w_mag   = {1'b0, w_abs_r} + {1'b0, w_abs_i};

    assign w_div   = (r_as == '0) ? {{(S-1){1'b0}}, 1'b1} : r_as;
    assign w_nmag  = r_sum[SUM_W-1] ? (SUM_W'(0) - r_sum) : r_sum;
    assign w_trial = {r_rem, r_q[31]};
    assign w_quo   = r_dsat ? '1 : r_q;
    assign w_err   = r_neg ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});

    assign w_xr = $signed({{(SUM_W-SAMPLE_BITS){r_xr[SAMPLE_BITS-1]}}, r_xr}) <<< IN_SH;
    assign w_xi = $signed({{(SUM_W-SAMPLE_BITS){r_xi[SAMPLE_BITS-1]}}, r_xi}) <<< IN_SH;

    // Operand select for the shared multiplier.
    always_comb begin
        w_a  = '0;
        w_b  = '0;
        w_sh = 2'd0;
        unique case (r_op)
            OP_S1_RR: begin w_a = A_W'(r_pr); w_b = B_W'(r_s1r); end
            OP_S1_II: begin w_a = A_W'(r_pi); w_b = B_W'(r_s1i); end
            OP_S1_RI: begin w_a = A_W'(r_pr); w_b = B_W'(r_s1i); end
            OP_S1_IR: begin w_a = A_W'(r_pi); w_b = B_W'(r_s1r); end
            OP_S2_RR: begin w_a = A_W'(r_pr); w_b = B_W'(r_s2r); end
            OP_S2_II: begin w_a = A_W'(r_pi); w_b = B_W'(r_s2i); end
            OP_S2_RI: begin w_a = A_W'(r_pr); w_b = B_W'(r_s2i); end
            OP_S2_IR: begin w_a = A_W'(r_pi); w_b = B_W'(r_s2r); end
            OP_AMP_F: begin
                w_a = $signed({2'b00, r_sc});
                w_b = $signed(w_mag) - $signed({2'b00, r_af});
            end
            OP_AMP_S: begin
                w_a = $signed({2'b00, r_sc});
                w_b = $signed({2'b00, r_af}) - $signed({2'b00, r_as});
            end
            OP_COS:   begin w_a = A_W'(w_cos); w_b = B_W'(r_s2i); w_sh = 2'd1; end
            OP_SIN:   begin w_a = A_W'(w_sin); w_b = B_W'(r_s2r); w_sh = 2'd1; end
            OP_INT:   begin
                w_a = $signed({2'b00, r_ic}); w_b = B_W'(w_err); w_sh = 2'd2;
            end
            OP_PROP:  begin
                w_a = $signed({2'b00, r_pc}); w_b = B_W'(w_err); w_sh = 2'd2;
            end
            default:  begin w_a = '0; w_b = '0; w_sh = 2'd0; end
        endcase
    end

    assign w_mb = (r_state == ST_HI)
                ? $signed({{(31-BH_W){w_b[B_W-1]}}, w_b[B_W-1:30]})
                : $signed({1'b0, w_b[29:0]});
    assign w_prod   = w_a * w_mb;
    assign w_prod_x = $signed({{(P_W-64){w_prod[63]}}, w_prod});

    always_comb begin
        unique case (w_sh)
            2'd1:    w_res = (r_acc + RND15) >>> 15;
            2'd2:    w_res = (r_acc + RND20) >>> 20;
            default: w_res = (r_acc + RND30) >>> 30;
        endcase
    end
    assign w_rs    = w_res[SUM_W-1:0];
    assign w_total = r_freq + w_res[39:0] + 40'd128;

    assign o_sample_ready = (r_state == ST_IDLE);
    assign o_phase_valid  = r_ov;
    assign o_phase_out    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_S1_RR;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
            r_pr    <= '0;
            r_pi    <= '0;
            r_sc    <= ptpll_pkg::SMOOTHER_RST;
            r_ic    <= ptpll_pkg::INTEGRATOR_RST;
            r_pc    <= ptpll_pkg::PROPORTION_RST;
            r_s1r   <= '0;
            r_s1i   <= '0;
            r_s2r   <= '0;
            r_s2i   <= '0;
            r_af    <= sat_cfg_amp(ptpll_pkg::AMP_START_RST);
            r_as    <= sat_cfg_amp(ptpll_pkg::AMP_START_RST);
            r_freq  <= '0;
            r_phase <= '0;
        end else begin
            if (r_ov && i_phase_ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ptpll_pkg::CFG_POLE_REAL:  r_pr <= i_cfg_data[31:0];
                    ptpll_pkg::CFG_POLE_IMAG:  r_pi <= i_cfg_data[31:0];
                    ptpll_pkg::CFG_SMOOTHER:   r_sc <= i_cfg_data[30:0];
                    ptpll_pkg::CFG_INTEGRATOR: r_ic <= i_cfg_data[30:0];
                    ptpll_pkg::CFG_PROPORTION: r_pc <= i_cfg_data[30:0];
                    ptpll_pkg::CFG_AMP_START: begin
                        r_af <= sat_cfg_amp(i_cfg_data);
                        r_as <= sat_cfg_amp(i_cfg_data);
                    end
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_sample_valid) begin
                        r_xr    <= i_sample_re;
                        r_xi    <= i_sample_im;
                        r_op    <= OP_S1_RR;
                        r_state <= ST_LO;
                    end
                end
                ST_LO: begin
                    r_acc   <= w_prod_x;
                    r_state <= ST_HI;
                end
                ST_HI: begin
                    r_acc   <= r_acc + (w_prod_x <<< 30);
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    r_state <= ST_LO;
                    r_op    <= r_op + 4'd1;
                    unique case (r_op)
                        OP_S1_RR: r_sum <= w_xr + w_rs;
                        OP_S1_II: r_sum <= r_sum - w_rs;
                        OP_S1_RI: begin
                            r_hold <= sat_state(r_sum);
                            r_sum  <= w_xi + w_rs;
                        end
                        OP_S1_IR: begin
                            r_s1i <= sat_state(r_sum + w_rs);
                            r_s1r <= r_hold;
                        end
                        OP_S2_RR: r_sum <= SUM_W'(r_s1r) + w_rs;
                        OP_S2_II: r_sum <= r_sum - w_rs;
                        OP_S2_RI: begin
                            r_hold <= sat_state(r_sum);
                            r_sum  <= SUM_W'(r_s1i) + w_rs;
                        end
                        OP_S2_IR: begin
                            r_s2i <= sat_state(r_sum + w_rs);
                            r_s2r <= r_hold;
                        end
                        OP_AMP_F: r_af <= sat_amp($signed({4'b0000, r_af}) + w_rs);
                        OP_AMP_S: r_as <= sat_amp($signed({4'b0000, r_as}) + w_rs);
                        OP_COS:   r_sum <= w_rs;
                        OP_SIN: begin
                            r_sum   <= r_sum - w_rs;
                            r_state <= ST_DINIT;
                        end
                        OP_INT:   r_freq <= r_freq + w_res[39:0];
                        OP_PROP: begin
                            r_phase <= r_phase + w_total[39:8];
                            r_state <= ST_FIN;
                        end
                        default:  r_state <= ST_IDLE;
                    endcase
                end
                ST_DINIT: begin
                    r_neg   <= r_sum[SUM_W-1];
                    r_dsat  <= (w_nmag >= SUM_W'({w_div, 2'b00}));
                    r_rem   <= w_nmag[S+1:2];
                    r_q     <= {w_nmag[1:0], 30'd0};
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (w_trial >= {1'b0, w_div}) begin
                        r_rem <= S'(w_trial - {1'b0, w_div});
                        r_q   <= {r_q[30:0], 1'b1};
                    end else begin
                        r_rem <= w_trial[S-1:0];
                        r_q   <= {r_q[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_op    <= OP_INT;
                        r_state <= ST_LO;
                    end
                end
                ST_FIN: begin
                    if (!r_ov || i_phase_ready) begin
                        r_out   <= r_phase;
                        r_ov    <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample_valid && o_sample_ready) |=> (r_state == ST_LO && r_op == OP_S1_RR))
        else $error("item accept did not start the sequence");

    a_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && !r_dsat) |-> (r_rem < w_div))
        else $error("divider remainder not below divisor");

    a_div_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (w_div != '0))
        else $error("zero divisor");

    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && r_ov && !i_phase_ready) |=> (r_state == ST_FIN))
        else $error("result overwrote a pending item");

endmodule

@@ dv/pilot_tone_pll_tracker_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench of pilot_tone_pll_tracker_core: drives samples and register writes,
// predicts each tracked phase in place and checks the phase stream in order.
// Depends on ptpll_pkg and the tracker RTL.
module pilot_tone_pll_tracker_core_tb;

    localparam int  LIMIT_CYCLES = 2000000;
    localparam int  MAX_SHOWN    = 10;

    localparam ptpll_pkg::t_cfg_idx CFG_SPARE_LO = 3'd6;
    localparam ptpll_pkg::t_cfg_idx CFG_SPARE_HI = 3'd7;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [ptpll_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [ptpll_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                             i_sample_valid = 1'b0;
    logic                             o_sample_ready;
    logic signed [15:0]               i_sample_re = '0;
    logic signed [15:0]               i_sample_im = '0;
    logic                             o_phase_valid;
    logic                             i_phase_ready = 1'b0;
    logic [ptpll_pkg::PHASE_W-1:0]    o_phase_out;

    pilot_tone_pll_tracker_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample_re    (i_sample_re),
        .i_sample_im    (i_sample_im),
        .o_phase_valid  (o_phase_valid),
        .i_phase_ready  (i_phase_ready),
        .o_phase_out    (o_phase_out)
    );

    // tracker mirror: registers and state
    longint      pole_re, pole_im, smooth_k, integ_k, prop_k;
    logic [39:0] amp_init;
    longint      s1_re, s1_im, s2_re, s2_im, amp_fast, amp_slow;
    logic [39:0] freq_acc;
    logic [31:0] phase_acc;

    logic [31:0] phase_expected[$];
    int          sender_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_off_cycles = 0;
    int          samples_sent = 0;
    int          phases_checked = 0;
    int          mismatches = 0;
    int          cfg_writes = 0;
    longint      cycle_count = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_phase_ready <= 1'b0;
        end else begin
            i_phase_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n && o_phase_valid && i_phase_ready) begin
            if (phase_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("Unexpected phase %h", o_phase_out);
            end else begin
                want = phase_expected.pop_front();
                phases_checked++;
                if (want !== o_phase_out) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("Phase %0d: expected %h, got %h",
                                 phases_checked, want, o_phase_out);
                end
            end
        end
    end

    function automatic longint round_q30(longint a, longint b);
        longint bh;
        longint bl;
        bh = b >>> 30;
        bl = b - (bh <<< 30);
        return a * bh + ((a * bl + (64'sd1 <<< 29)) >>> 30);
    endfunction

    function automatic longint round_q15(longint b, longint t);
        longint bh;
        longint bl;
        bh = b >>> 15;
        bl = b - (bh <<< 15);
        return bh * t + ((bl * t + 64'sd16384) >>> 15);
    endfunction

    function automatic longint clamp_state(longint v);
        longint top;
        top = (64'sd1 <<< 39) - 1;
        return (v > top) ? top : ((v < -top - 1) ? -top - 1 : v);
    endfunction

    function automatic longint clamp_amp(longint v);
        longint top;
        top = (64'sd1 <<< 40) - 1;
        return (v < 0) ? 64'sd0 : ((v > top) ? top : v);
    endfunction

    function automatic longint phase_sine(logic [31:0] ph);
        logic [9:0] idx;
        longint     k;
        longint     x;
        longint     x2;
        longint     t;
        longint     s;
        idx = ph[31:22];
        k = idx[7:0];
        if (idx[8]) k = 256 - k;
        x  = (k * ptpll_pkg::HALF_PI_Q30) >>> 8;
        x2 = (x * x + (64'sd1 <<< 29)) >>> 30;
        t  = ptpll_pkg::ONE_Q30 - x2 / 72;
        t  = ptpll_pkg::ONE_Q30 - ((x2 * t) >>> 30) / 42;
        t  = ptpll_pkg::ONE_Q30 - ((x2 * t) >>> 30) / 20;
        t  = ptpll_pkg::ONE_Q30 - ((x2 * t) >>> 30) / 6;
        s  = (((x * t) >>> 30) + 64'sd16384) >>> 15;
        if (s > 32768) s = 32768;
        return idx[9] ? -s : s;
    endfunction

    function automatic logic [63:0] error_quotient(logic [63:0] n, logic [63:0] d);
        logic [63:0] rem;
        logic [63:0] q;
        rem = 0;
        q = 0;
        for (int i = 0; i < 94; i++) begin
            rem = {rem[62:0], (i < 64) ? n[63 - i] : 1'b0};
            q = q << 1;
            if (rem >= d) begin
                rem = rem - d;
                q[0] = 1'b1;
            end
            if (q > 64'hFFFF_FFFF) return 64'hFFFF_FFFF;
        end
        return q;
    endfunction

    function automatic void reset_tracker();
        pole_re = 0;
        pole_im = 0;
        smooth_k = ptpll_pkg::SMOOTHER_RST;
        integ_k = ptpll_pkg::INTEGRATOR_RST;
        prop_k = ptpll_pkg::PROPORTION_RST;
        amp_init = ptpll_pkg::AMP_START_RST;
        s1_re = 0; s1_im = 0; s2_re = 0; s2_im = 0;
        amp_fast = amp_init;
        amp_slow = amp_init;
        freq_acc = 0;
        phase_acc = 0;
    endfunction

    function automatic logic [31:0] track_phase(logic signed [15:0] re, logic signed [15:0] im);
        longint      nr, ni, mag, cs, sn, num, err, inc, prop;
        logic [63:0] nmag, divisor, emag, total;
        nr = longint'(re) * 512 + round_q30(pole_re, s1_re) - round_q30(pole_im, s1_im);
        ni = longint'(im) * 512 + round_q30(pole_re, s1_im) + round_q30(pole_im, s1_re);
        s1_re = clamp_state(nr);
        s1_im = clamp_state(ni);
        nr = s1_re + round_q30(pole_re, s2_re) - round_q30(pole_im, s2_im);
        ni = s1_im + round_q30(pole_re, s2_im) + round_q30(pole_im, s2_re);
        s2_re = clamp_state(nr);
        s2_im = clamp_state(ni);
        mag = (s2_re < 0 ? -s2_re : s2_re) + (s2_im < 0 ? -s2_im : s2_im);
        amp_fast = clamp_amp(amp_fast + round_q30(smooth_k, mag - amp_fast));
        amp_slow = clamp_amp(amp_slow + round_q30(smooth_k, amp_fast - amp_slow));
        cs = phase_sine(phase_acc + 32'h4000_0000);
        sn = phase_sine(phase_acc);
        num = round_q15(s2_im, cs) - round_q15(s2_re, sn);
        nmag = (num < 0) ? -num : num;
        divisor = (amp_slow < 1) ? 64'd1 : amp_slow;
        emag = error_quotient(nmag, divisor);
        err = (num < 0) ? -longint'(emag) : longint'(emag);
        inc = (integ_k * err + (64'sd1 <<< 19)) >>> 20;
        freq_acc = freq_acc + inc[39:0];
        prop = (prop_k * err + (64'sd1 <<< 19)) >>> 20;
        total = {24'd0, freq_acc} + prop + 64'd128;
        phase_acc = phase_acc + total[39:8];
        return phase_acc;
    endfunction

    task automatic write_reg(ptpll_pkg::t_cfg_idx idx,
                             logic [ptpll_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_writes++;
        case (idx)
            ptpll_pkg::CFG_POLE_REAL:  pole_re = longint'(signed'(data[31:0]));
            ptpll_pkg::CFG_POLE_IMAG:  pole_im = longint'(signed'(data[31:0]));
            ptpll_pkg::CFG_SMOOTHER:   smooth_k = data[30:0];
            ptpll_pkg::CFG_INTEGRATOR: integ_k = data[30:0];
            ptpll_pkg::CFG_PROPORTION: prop_k = data[30:0];
            ptpll_pkg::CFG_AMP_START: begin
                amp_init = data;
                amp_fast = amp_init;
                amp_slow = amp_init;
            end
            default: ;
        endcase
    endtask

    task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_sample_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_sample_valid <= 1'b1;
        i_sample_re <= re;
        i_sample_im <= im;
        do @(posedge i_clk); while (!o_sample_ready);
        phase_expected.push_back(track_phase(re, im));
        samples_sent++;
    endtask

    task automatic wait_idle();
        i_sample_valid <= 1'b0;
        while (phase_expected.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic pick_settings();
        write_reg(ptpll_pkg::CFG_POLE_REAL, $urandom_range(7) == 0 ? 40'h0_7FFF_FFFF :
                  {8'd0, 32'($urandom_range(2200000000) - 1100000000)});
        write_reg(ptpll_pkg::CFG_POLE_IMAG, $urandom_range(7) == 0 ? 40'h0_8000_0000 :
                  {8'd0, 32'($urandom_range(600000000) - 300000000)});
        write_reg(ptpll_pkg::CFG_SMOOTHER, $urandom_range(9) == 0 ? 40'd1073741824 :
                  40'($urandom_range(200000000)));
        write_reg(ptpll_pkg::CFG_INTEGRATOR, $urandom_range(9) == 0 ? 40'd1073741824 :
                  40'($urandom_range(3000000)));
        write_reg(ptpll_pkg::CFG_PROPORTION, $urandom_range(9) == 0 ? 40'd0 :
                  40'($urandom_range(60000000)));
        write_reg(ptpll_pkg::CFG_AMP_START,
                  {8'($urandom_range(255)), 32'($urandom())} | 40'd1);
    endtask

    task automatic run_random(int count, int idle_pct, int stall_pct);
        logic [31:0] tone;
        logic [31:0] step;
        int          amp;
        wait_idle();
        pick_settings();
        sender_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        tone = $urandom();
        step = $urandom_range(80000000);
        amp = $urandom_range(32767);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(3) != 0) begin
                tone = tone + step;
                send_sample(16'((amp * phase_sine(tone + 32'h4000_0000)) >>> 15)
                            + 16'($urandom_range(63)) - 16'sd32,
                            16'((amp * phase_sine(tone)) >>> 15));
            end else begin
                send_sample(16'($urandom()), 16'($urandom()));
            end
        end
        sender_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_reset_defaults();
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sh7FFF, 16'sh7FFF);
        send_sample(-16'sh8000, -16'sh8000);
        send_sample(16'sh7FFF, -16'sh8000);
    endtask

    task automatic test_saturation();
        wait_idle();
        write_reg(ptpll_pkg::CFG_POLE_REAL, 40'h0_7FFF_FFFF);
        write_reg(ptpll_pkg::CFG_POLE_IMAG, 40'h0_8000_0000);
        write_reg(ptpll_pkg::CFG_SMOOTHER, 40'd1073741824);
        write_reg(ptpll_pkg::CFG_INTEGRATOR, 40'd1073741824);
        write_reg(ptpll_pkg::CFG_PROPORTION, 40'd1073741824);
        write_reg(ptpll_pkg::CFG_AMP_START, 40'hFF_FFFF_FFFF);
        for (int n = 0; n < 8; n++) send_sample(16'sh7FFF, -16'sh8000);
        for (int n = 0; n < 4; n++) send_sample(-16'sh8000, 16'sh7FFF);
    endtask

    task automatic test_zero_amplitude();
        wait_idle();
        write_reg(ptpll_pkg::CFG_POLE_REAL, 40'd0);
        write_reg(ptpll_pkg::CFG_POLE_IMAG, 40'd0);
        write_reg(ptpll_pkg::CFG_SMOOTHER, 40'd1073741824);
        write_reg(ptpll_pkg::CFG_INTEGRATOR, 40'd0);
        write_reg(ptpll_pkg::CFG_PROPORTION, 40'd1073741824);
        write_reg(ptpll_pkg::CFG_AMP_START, 40'd1);
        write_reg(CFG_SPARE_LO, 40'h12_3456_789A);
        write_reg(CFG_SPARE_HI, 40'hFF_FFFF_FFFF);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd1);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd1, -16'sd1);
    endtask

    task automatic test_backpressure();
        wait_idle();
        pick_settings();
        hold_off_cycles = 800;
        for (int n = 0; n < 40; n++) send_sample(16'($urandom()), 16'($urandom()));
    endtask

    initial begin
        reset_tracker();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_saturation();
        test_zero_amplitude();
        run_random(450, 0, 0);
        run_random(400, 77, 0);
        run_random(400, 0, 77);
        run_random(450, 24, 24);
        run_random(150, 0, 0);
        test_backpressure();
        wait_idle();
        $display("Sent %0d samples over %0d register writes; %0d phases checked, %0d mismatches",
                 samples_sent, cfg_writes, phases_checked, mismatches);
        if (mismatches == 0 && phase_expected.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
